@@ hw/rtl/shs_pkg.sv @@
`default_nettype none

package shs_pkg;

    localparam int QUEUE_DEPTH = 16;

    // one 32-bit schedule word in flight from the front to the back
    typedef struct packed {
        logic [31:0] word;
        logic        last;    // length word that closes the final block
    } t_qent;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_PAD,
        FS_ZERO,
        FS_LEN_HI,
        FS_LEN_LO
    } t_fstate;

    typedef enum logic [1:0] {
        BS_LOAD,
        BS_ROUND,
        BS_ADD
    } t_bstate;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [3:0] LEN_HI_POS = 4'd14;

    function automatic logic [31:0] round_k(input logic [5:0] t);
        logic [31:0] k;
        case (t)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/sha256_stream_hasher_unit.sv @@
// Streaming SHA-256: one message byte per input transfer, with end_of_message
// closing the message (has_byte low gives a bare end marker, so empty
// messages work). The front packs bytes into 32-bit words and generates the
// padding and 64-bit length words; a word queue feeds the back, which runs one
// compression round per cycle unless waiting on the queue or on a digest
// readout, 64 rounds and then an add step per block, taking message words
// from the queue during rounds 0..15. Bytes are taken at one per cycle while
// the queue has room and no padding is being queued. After end_of_message the
// input stalls while padding is queued (longer while the queue is full), and
// the digest appears one or two blocks later as eight transfers, word 0 first;
// the next message can start while the digest is still being read out.
`default_nettype none

module sha256_stream_hasher_unit #(
    parameter int QueueDepth = shs_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_has_byte,
    input  wire logic          i_end_of_message,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [31:0]        o_digest_word,
    output logic [2:0]         o_word_index,
    output logic               o_last_word
);
    import shs_pkg::*;

    t_qent  push_ent;
    t_qent  pop_ent;
    logic   push;
    logic   full;
    logic   pop;
    logic   empty;

    shs_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .i_has_byte       (i_has_byte),
        .i_end_of_message (i_end_of_message),
        .o_push           (push),
        .o_push_ent       (push_ent),
        .i_full           (full)
    );

    shs_fifo #(
        .Depth (QueueDepth)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_ent (push_ent),
        .o_full     (full),
        .i_pop      (pop),
        .o_pop_ent  (pop_ent),
        .o_empty    (empty)
    );

    shs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_ent       (pop_ent),
        .i_q_empty     (empty),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

`default_nettype wire

@@ hw/rtl/shs_fifo.sv @@
`default_nettype none

module shs_fifo #(
    parameter int Depth = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire shs_pkg::t_qent i_push_ent,
    output logic               o_full,
    input  wire logic          i_pop,
    output shs_pkg::t_qent     o_pop_ent,
    output logic               o_empty
);
    import shs_pkg::*;

    localparam int AW = $clog2(Depth);
    localparam logic [AW-1:0] LAST_PTR = AW'(Depth - 1);
    localparam logic [AW:0]   FULL_CNT = (AW + 1)'(Depth);

    t_qent           r_mem [Depth];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [AW:0]     r_cnt;
    logic            push_ok;
    logic            pop_ok;

    assign o_full    = (r_cnt == FULL_CNT);
    assign o_empty   = (r_cnt == '0);
    assign push_ok   = i_push && !o_full;
    assign pop_ok    = i_pop && !o_empty;
    assign o_pop_ent = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_push_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/shs_front.sv @@
`default_nettype none

module shs_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_data_byte,
    input  wire logic          i_has_byte,
    input  wire logic          i_end_of_message,
    output logic               o_push,
    output shs_pkg::t_qent     o_push_ent,
    input  wire logic          i_full
);
    import shs_pkg::*;

    t_fstate      r_st, n_st;
    logic [23:0]  r_acc, n_acc;
    logic [1:0]   r_bpos, n_bpos;
    logic [3:0]   r_wpos, n_wpos;
    logic [60:0]  r_len, n_len;
    logic         take;
    logic [31:0]  pad_word;

    assign o_stall = (r_st != FS_IDLE) || i_full;
    assign take    = i_valid && !o_stall;

    // held bytes, then the 0x80 marker, then zeros
    always_comb begin
        case (r_bpos)
            2'd0:    pad_word = {PAD_BYTE, 24'h0};
            2'd1:    pad_word = {r_acc[7:0], PAD_BYTE, 16'h0};
            2'd2:    pad_word = {r_acc[15:0], PAD_BYTE, 8'h0};
            2'd3:    pad_word = {r_acc[23:0], PAD_BYTE};
            default: pad_word = '0;
        endcase
    end

    always_comb begin
        n_st       = r_st;
        n_acc      = r_acc;
        n_bpos     = r_bpos;
        n_wpos     = r_wpos;
        n_len      = r_len;
        o_push     = 1'b0;
        o_push_ent = '0;
        case (r_st)
            FS_IDLE: begin
                if (take) begin
                    if (i_has_byte) begin
                        n_len  = r_len + 61'd1;
                        n_bpos = r_bpos + 2'd1;
                        n_acc  = {r_acc[15:0], i_data_byte};
                        if (r_bpos == 2'd3) begin
                            o_push          = 1'b1;
                            o_push_ent.word = {r_acc, i_data_byte};
                            n_wpos          = r_wpos + 4'd1;
                        end
                    end
                    if (i_end_of_message) begin
                        n_st = FS_PAD;
                    end
                end
            end
            FS_PAD: begin
                if (!i_full) begin
                    o_push          = 1'b1;
                    o_push_ent.word = pad_word;
                    n_wpos          = r_wpos + 4'd1;
                    n_bpos          = 2'd0;
                    n_st = (n_wpos == LEN_HI_POS) ? FS_LEN_HI : FS_ZERO;
                end
            end
            FS_ZERO: begin
                if (!i_full) begin
                    o_push = 1'b1;
                    n_wpos = r_wpos + 4'd1;
                    if (n_wpos == LEN_HI_POS) begin
                        n_st = FS_LEN_HI;
                    end
                end
            end
            FS_LEN_HI: begin
                if (!i_full) begin
                    o_push          = 1'b1;
                    o_push_ent.word = r_len[60:29];
                    n_wpos          = r_wpos + 4'd1;
                    n_st            = FS_LEN_LO;
                end
            end
            FS_LEN_LO: begin
                if (!i_full) begin
                    o_push          = 1'b1;
                    o_push_ent.word = {r_len[28:0], 3'b000};
                    o_push_ent.last = 1'b1;
                    n_wpos          = 4'd0;
                    n_len           = '0;
                    n_st            = FS_IDLE;
                end
            end
            default: begin
                n_st = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= FS_IDLE;
            r_bpos <= '0;
            r_wpos <= '0;
            r_len  <= '0;
        end else begin
            r_st   <= n_st;
            r_bpos <= n_bpos;
            r_wpos <= n_wpos;
            r_len  <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

endmodule

`default_nettype wire

@@ hw/rtl/shs_back.sv @@
`default_nettype none

module shs_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire shs_pkg::t_qent i_q_ent,
    input  wire logic          i_q_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [31:0]        o_digest_word,
    output logic [2:0]         o_word_index,
    output logic               o_last_word
);
    import shs_pkg::*;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    t_bstate      r_st, n_st;
    logic [5:0]   r_rnd, n_rnd;
    logic         r_final, n_final;
    logic [31:0]  r_v [8];
    logic [31:0]  r_h [8];
    logic [31:0]  r_w [16];
    logic [31:0]  r_dig [8];
    logic [2:0]   r_ocnt;
    logic         r_obusy;

    logic         do_round;
    logic         do_add;
    logic [31:0]  w_new, wt, t1, t2;
    logic [31:0]  ss0, ss1, bs0, bs1, ch, maj;

    assign o_pop    = (r_st == BS_LOAD) && !i_q_empty;
    assign do_round = o_pop || (r_st == BS_ROUND);
    // the final block waits here until the previous digest has drained
    assign do_add   = (r_st == BS_ADD) && !(r_final && r_obusy);

    always_comb begin
        ss0   = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        ss1   = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + ss0 + r_w[9] + ss1;
        wt    = (r_st == BS_LOAD) ? i_q_ent.word : w_new;
        bs1   = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1    = r_v[7] + bs1 + ch + round_k(r_rnd) + wt;
        bs0   = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2    = bs0 + maj;
    end

    always_comb begin
        n_st    = r_st;
        n_rnd   = r_rnd;
        n_final = r_final;
        case (r_st)
            BS_LOAD: begin
                if (o_pop) begin
                    n_rnd = r_rnd + 6'd1;
                    if (r_rnd == 6'd15) begin
                        n_final = i_q_ent.last;
                        n_st    = BS_ROUND;
                    end
                end
            end
            BS_ROUND: begin
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_st = BS_ADD;
                end
            end
            BS_ADD: begin
                if (do_add) begin
                    n_rnd = '0;
                    n_st  = BS_LOAD;
                end
            end
            default: begin
                n_st = BS_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= BS_LOAD;
            r_rnd   <= '0;
            r_final <= 1'b0;
            r_obusy <= 1'b0;
            r_ocnt  <= '0;
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= H_INIT[i];
                r_h[i] <= H_INIT[i];
            end
        end else begin
            r_st    <= n_st;
            r_rnd   <= n_rnd;
            r_final <= n_final;
            if (do_round) begin
                r_v[0] <= t1 + t2;
                r_v[1] <= r_v[0];
                r_v[2] <= r_v[1];
                r_v[3] <= r_v[2];
                r_v[4] <= r_v[3] + t1;
                r_v[5] <= r_v[4];
                r_v[6] <= r_v[5];
                r_v[7] <= r_v[6];
            end else if (do_add) begin
                for (int i = 0; i < 8; i++) begin
                    if (r_final) begin
                        r_h[i] <= H_INIT[i];
                        r_v[i] <= H_INIT[i];
                    end else begin
                        r_h[i] <= r_h[i] + r_v[i];
                        r_v[i] <= r_h[i] + r_v[i];
                    end
                end
            end
            if (do_add && r_final) begin
                r_obusy <= 1'b1;
                r_ocnt  <= '0;
            end else if (r_obusy && !i_stall) begin
                r_ocnt <= r_ocnt + 3'd1;
                if (r_ocnt == 3'd7) begin
                    r_obusy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_round) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= wt;
        end
        if (do_add && r_final) begin
            for (int i = 0; i < 8; i++) begin
                r_dig[i] <= r_h[i] + r_v[i];
            end
        end else if (r_obusy && !i_stall) begin
            for (int i = 0; i < 7; i++) begin
                r_dig[i] <= r_dig[i + 1];
            end
        end
    end

    assign o_valid       = r_obusy;
    assign o_digest_word = r_dig[0];
    assign o_word_index  = r_ocnt;
    assign o_last_word   = (r_ocnt == 3'd7);

endmodule

`default_nettype wire

@@ hw/rtl/shs_chk.sv @@
`default_nettype none

module shs_chk (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          o_stall,
    input  wire logic          i_end_of_message,
    input  wire logic          o_valid,
    input  wire logic          i_stall,
    input  wire logic [31:0]   o_digest_word,
    input  wire logic [2:0]    o_word_index,
    input  wire logic          o_last_word
);

    // a stalled digest word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_digest_word)
                                  && $stable(o_word_index)))
        else $error("digest word changed while stalled");

    // the eight words of one digest come back to back in index order
    a_out_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_word) |=>
            (o_valid && o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest word sequence broken");

    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last word flag does not match index");

    // padding is generated right after the end marker, so input must stall
    a_pad_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_end_of_message) |=> o_stall)
        else $error("input taken while padding a message");

endmodule

bind sha256_stream_hasher_unit shs_chk u_chk (.*);

`default_nettype wire
